FILE: design/csp_pkg.sv
`timescale 1ns / 1ps
// csp_pkg: shared constants for the channel scan pairing block
// register map, event codes, field widths and reset values; no dependencies

package csp_pkg;

    // configuration register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_SERVER_ID     = 3'd0;
    localparam logic [2:0] REG_START_CHANNEL = 3'd1;
    localparam logic [2:0] REG_MAX_CHANNEL   = 3'd2;
    localparam logic [2:0] REG_REPLY_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_SCAN_LIMIT    = 3'd4;
    localparam logic [2:0] REG_PAUSE_MS      = 3'd5;
    localparam logic [2:0] REG_FAIL_LIMIT    = 3'd6;

    // event codes carried by req_type
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_SEND_DONE = 2'd1;
    localparam logic [1:0] REQ_PAIR_MSG  = 2'd2;
    localparam logic [1:0] REQ_RESET     = 2'd3;

    // widths
    localparam int ADDR_W    = 48;
    localparam int CHAN_W    = 4;
    localparam int TIMER_W   = 16;
    localparam int ATTEMPT_W = 6;
    localparam int FAIL_W    = 4;
    localparam int ID_W      = 8;

    // reset values of the registers
    localparam logic [ID_W-1:0]      RST_SERVER_ID     = 8'd0;
    localparam logic [CHAN_W-1:0]    RST_START_CHANNEL = 4'd1;
    localparam logic [CHAN_W-1:0]    RST_MAX_CHANNEL   = 4'd11;
    localparam logic [TIMER_W-1:0]   RST_REPLY_TIMEOUT = 16'd500;
    localparam logic [ATTEMPT_W-1:0] RST_SCAN_LIMIT    = 6'd22;
    localparam logic [TIMER_W-1:0]   RST_PAUSE_MS      = 16'd10000;
    localparam logic [FAIL_W-1:0]    RST_FAIL_LIMIT    = 4'd3;

    // first and last channel and broadcast station address
    localparam logic [CHAN_W-1:0] FIRST_CHANNEL  = 4'd1;
    localparam logic [CHAN_W-1:0] LAST_CHANNEL   = 4'd15;
    localparam logic [ADDR_W-1:0] BROADCAST_ADDR = {ADDR_W{1'b1}};

endpackage

FILE: design/channel_scan_pairing_fsm.sv
`timescale 1ns / 1ps
// channel_scan_pairing_fsm: client side of a channel-scanning pairing handshake
// depends on csp_pkg for register map, event codes and reset values
//
// Usage:
//   s_ channel: one event item per handshake (tick, send completion, pairing
//   message or pairing reset). m_ channel: one result item per event with the
//   link state, request strobe, active channel and latched peer data.
//   APB port sets server id, channel range, timeouts and limits; registers
//   sit at byte addresses 0x00..0x18, reads return the stored value.
//   Latency: the result of an item is valid the cycle after its acceptance.
//   Throughput: one item per cycle while the receiver takes results; the state
//   update is a single pass of counter and compare logic between the state
//   registers and the result register.
//   When the receiver stalls, the result register holds and s_ready drops;
//   s_ready is high whenever the result register is empty or being drained.
//   Reset (aresetn low, synchronous) returns the link to the request state on
//   channel 1, clears counters and result valid, loads register defaults and
//   sets the peer address to broadcast.

module channel_scan_pairing_fsm
    import csp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input event channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic               s_send_failed,
    input  logic [ID_W-1:0]    s_sender_id,
    input  logic [CHAN_W-1:0]  s_sender_channel,
    input  logic [ADDR_W-1:0]  s_sender_address,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_link_state,
    output logic               m_send_request,
    output logic [CHAN_W-1:0]  m_active_channel,
    output logic               m_save_channel,
    output logic [ADDR_W-1:0]  m_peer_address,
    output logic [CHAN_W-1:0]  m_peer_channel,
    output logic               m_paired_led,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [1:0] {
        ST_REQUEST   = 2'd0,
        ST_REQUESTED = 2'd1,
        ST_PAUSED    = 2'd2,
        ST_PAIRED    = 2'd3
    } link_t;

    // configuration registers
    logic [ID_W-1:0]      server_id_reg;
    logic [CHAN_W-1:0]    start_channel_reg;
    logic [CHAN_W-1:0]    max_channel_reg;
    logic [TIMER_W-1:0]   reply_timeout_reg;
    logic [ATTEMPT_W-1:0] scan_limit_reg;
    logic [TIMER_W-1:0]   pause_ms_reg;
    logic [FAIL_W-1:0]    fail_limit_reg;

    // link state
    link_t                link_reg, link_next;
    logic [CHAN_W-1:0]    channel_reg, channel_next;
    logic [ATTEMPT_W-1:0] attempt_reg, attempt_next;
    logic [TIMER_W-1:0]   wait_reg, wait_next;
    logic [TIMER_W-1:0]   pause_reg, pause_next;
    logic [FAIL_W-1:0]    fail_reg, fail_next;
    logic [ADDR_W-1:0]    srv_addr_reg, srv_addr_next;
    logic [CHAN_W-1:0]    srv_chan_reg, srv_chan_next;
    logic                 sent_next;
    logic                 save_next;

    // result register
    logic                 m_valid_reg;
    logic [1:0]           m_link_state_reg;
    logic                 m_send_request_reg;
    logic [CHAN_W-1:0]    m_active_channel_reg;
    logic                 m_save_channel_reg;
    logic [ADDR_W-1:0]    m_peer_address_reg;
    logic [CHAN_W-1:0]    m_peer_channel_reg;
    logic                 m_paired_led_reg;

    logic                 item_acc;
    logic                 cfg_wr;
    logic [2:0]           cfg_idx;
    logic [CHAN_W-1:0]    start_clamped;

    // arithmetic helpers
    logic [CHAN_W:0]      chan_inc;
    logic [ATTEMPT_W:0]   attempt_inc;
    logic [TIMER_W:0]     pause_inc;
    logic [FAIL_W:0]      fail_inc;

    assign s_ready  = !m_valid_reg || m_ready;
    assign item_acc = s_valid && s_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[4:2];

    // start channel written by software, pulled back to channel one if out of range (active channel only)
    always_comb begin
        if (pwdata[CHAN_W-1:0] == '0 || pwdata[CHAN_W-1:0] > max_channel_reg) begin
            start_clamped = FIRST_CHANNEL;
        end else begin
            start_clamped = pwdata[CHAN_W-1:0];
        end
    end

    // register read mux
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_SERVER_ID:     prdata = {24'd0, server_id_reg};
            REG_START_CHANNEL: prdata = {28'd0, start_channel_reg};
            REG_MAX_CHANNEL:   prdata = {28'd0, max_channel_reg};
            REG_REPLY_TIMEOUT: prdata = {16'd0, reply_timeout_reg};
            REG_SCAN_LIMIT:    prdata = {26'd0, scan_limit_reg};
            REG_PAUSE_MS:      prdata = {16'd0, pause_ms_reg};
            REG_FAIL_LIMIT:    prdata = {28'd0, fail_limit_reg};
            default:           prdata = '0;
        endcase
    end

    assign chan_inc    = {1'b0, channel_reg} + 1'b1;
    assign attempt_inc = {1'b0, attempt_reg} + 1'b1;
    assign pause_inc   = {1'b0, pause_reg} + 1'b1;
    assign fail_inc    = {1'b0, fail_reg} + 1'b1;

    // next state for one event item
    always_comb begin
        link_next     = link_reg;
        channel_next  = channel_reg;
        attempt_next  = attempt_reg;
        wait_next     = wait_reg;
        pause_next    = pause_reg;
        fail_next     = fail_reg;
        srv_addr_next = srv_addr_reg;
        srv_chan_next = srv_chan_reg;
        sent_next     = 1'b0;
        save_next     = 1'b0;
        unique case (s_req_type)
            REQ_TICK: begin
                unique case (link_reg)
                    ST_REQUEST: begin
                        sent_next = 1'b1;
                        wait_next = '0;
                        link_next = ST_REQUESTED;
                    end
                    ST_REQUESTED: begin
                        if (wait_reg >= reply_timeout_reg) begin
                            wait_next = '0;
                            // advance with wrap to channel one
                            if (chan_inc > {1'b0, max_channel_reg}
                                    || chan_inc > {1'b0, LAST_CHANNEL}) begin
                                channel_next = FIRST_CHANNEL;
                            end else begin
                                channel_next = chan_inc[CHAN_W-1:0];
                            end
                            attempt_next = attempt_inc[ATTEMPT_W] ? {ATTEMPT_W{1'b1}}
                                                                  : attempt_inc[ATTEMPT_W-1:0];
                            if (attempt_inc > {1'b0, scan_limit_reg}) begin
                                pause_next = '0;
                                link_next  = ST_PAUSED;
                            end else begin
                                link_next  = ST_REQUEST;
                            end
                        end else if (wait_reg != {TIMER_W{1'b1}}) begin
                            wait_next = wait_reg + 1'b1;
                        end
                    end
                    ST_PAUSED: begin
                        if (pause_inc >= {1'b0, pause_ms_reg}) begin
                            attempt_next = '0;
                            link_next    = ST_REQUEST;
                        end else begin
                            pause_next = pause_inc[TIMER_W-1:0];
                        end
                    end
                    ST_PAIRED: begin
                        // ticks do nothing once paired
                    end
                    default: begin
                    end
                endcase
            end
            REQ_SEND_DONE: begin
                if (!s_send_failed) begin
                    fail_next = '0;
                end else if (link_reg == ST_PAIRED) begin
                    if (fail_inc > {1'b0, fail_limit_reg}) begin
                        link_next = ST_REQUEST;
                        fail_next = '0;
                    end else begin
                        fail_next = fail_inc[FAIL_W-1:0];
                    end
                end
            end
            REQ_PAIR_MSG: begin
                if (s_sender_id == server_id_reg) begin
                    srv_addr_next = s_sender_address;
                    srv_chan_next = s_sender_channel;
                    save_next     = 1'b1;
                    link_next     = ST_PAIRED;
                end
            end
            REQ_RESET: begin
                link_next = ST_REQUEST;
            end
            default: begin
            end
        endcase
    end

    // state, configuration and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_id_reg     <= RST_SERVER_ID;
            start_channel_reg <= RST_START_CHANNEL;
            max_channel_reg   <= RST_MAX_CHANNEL;
            reply_timeout_reg <= RST_REPLY_TIMEOUT;
            scan_limit_reg    <= RST_SCAN_LIMIT;
            pause_ms_reg      <= RST_PAUSE_MS;
            fail_limit_reg    <= RST_FAIL_LIMIT;
            link_reg          <= ST_REQUEST;
            channel_reg       <= RST_START_CHANNEL;
            attempt_reg       <= '0;
            wait_reg          <= '0;
            pause_reg         <= '0;
            fail_reg          <= '0;
            srv_addr_reg      <= BROADCAST_ADDR;
            srv_chan_reg      <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (item_acc) begin
                link_reg     <= link_next;
                channel_reg  <= channel_next;
                attempt_reg  <= attempt_next;
                wait_reg     <= wait_next;
                pause_reg    <= pause_next;
                fail_reg     <= fail_next;
                srv_addr_reg <= srv_addr_next;
                srv_chan_reg <= srv_chan_next;
                // result payload, loaded with each accepted item
                m_link_state_reg     <= link_next;
                m_send_request_reg   <= sent_next;
                m_active_channel_reg <= channel_next;
                m_save_channel_reg   <= save_next;
                m_peer_address_reg   <= srv_addr_next;
                m_peer_channel_reg   <= srv_chan_next;
                m_paired_led_reg     <= (link_next == ST_PAIRED);
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_SERVER_ID:     server_id_reg <= pwdata[ID_W-1:0];
                    REG_START_CHANNEL: begin
                        start_channel_reg <= pwdata[CHAN_W-1:0];
                        channel_reg       <= start_clamped;
                    end
                    REG_MAX_CHANNEL:   max_channel_reg   <= pwdata[CHAN_W-1:0];
                    REG_REPLY_TIMEOUT: reply_timeout_reg <= pwdata[TIMER_W-1:0];
                    REG_SCAN_LIMIT:    scan_limit_reg    <= pwdata[ATTEMPT_W-1:0];
                    REG_PAUSE_MS:      pause_ms_reg      <= pwdata[TIMER_W-1:0];
                    REG_FAIL_LIMIT:    fail_limit_reg    <= pwdata[FAIL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (item_acc) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_link_state     = m_link_state_reg;
    assign m_send_request   = m_send_request_reg;
    assign m_active_channel = m_active_channel_reg;
    assign m_save_channel   = m_save_channel_reg;
    assign m_peer_address   = m_peer_address_reg;
    assign m_peer_channel   = m_peer_channel_reg;
    assign m_paired_led     = m_paired_led_reg;

endmodule
